FILE: sv/dc_level_estimator_top_macros.svh
// assertion macros shared by the dc level estimator modules
// each macro expects aclk and aresetn to be visible in the using module
`ifndef DC_LEVEL_ESTIMATOR_TOP_MACROS_SVH
`define DC_LEVEL_ESTIMATOR_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define DLE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dle_pkg.sv
// shared types and constants for the dc level estimator
// no dependencies
`timescale 1ns / 1ps

package dle_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int CH_W        = 4;
    localparam int SUM_W       = 27;
    localparam int LEVEL_W     = 32;
    localparam int OUT_LEVEL_W = 24;
    localparam int RECIP_W     = 25;
    localparam int ALPHA_W     = 16;
    localparam int CNT_W       = 10;

    // stream and config port widths
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 25;

    // default channel count
    localparam int N_CHAN_DEF = 2;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // register reset values
    localparam logic [RECIP_W-1:0] RECIP_RESET    = 25'd34953;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd3277;
    localparam logic [CNT_W-1:0]   RELIABLE_RESET = 10'd100;

    // saturation limits
    localparam logic signed [SUM_W:0] SUM_MAX = 28'sd67108863;
    localparam logic signed [SUM_W:0] SUM_MIN = -28'sd67108864;
    localparam logic [CNT_W-1:0]      CNT_MAX = 10'd1023;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RECIP    = 2'd0,
        CFG_ALPHA    = 2'd1,
        CFG_RELIABLE = 2'd2
    } cfg_idx_t;

    // one channel frame handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CH_W-1:0]         ch;
        logic                    reliable;
        logic                    frame_done;
    } dle_job_t;

endpackage

FILE: sv/dle_front.sv
// front end: sample accumulation, frame counting and job issue
// depends on dle_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dc_level_estimator_top_macros.svh"

module dle_front #(
    parameter int N_CHAN = dle_pkg::N_CHAN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dle_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tuser,
    input  logic [dle_pkg::CNT_W-1:0]     reliable_count,
    input  logic                          queue_full,
    output logic                          push,
    output dle_pkg::dle_job_t             job
);

    logic signed [dle_pkg::SUM_W-1:0]    sum_reg;
    logic signed [dle_pkg::SUM_W-1:0]    sum_next;
    logic [dle_pkg::CNT_W-1:0]           frames_reg;
    logic [dle_pkg::CNT_W-1:0]           cnt_inc;
    logic signed [dle_pkg::SAMPLE_W-1:0] sample;
    logic [dle_pkg::CH_W-1:0]            ch;
    logic signed [dle_pkg::SUM_W:0]      sum_wide;
    logic                                chan_end;
    logic                                in_range;
    logic                                accept;

    // beat unpacking
    assign sample   = $signed(s_tdata[dle_pkg::SAMPLE_W-1:0]);
    assign ch       = s_tdata[dle_pkg::SAMPLE_W +: dle_pkg::CH_W];
    assign chan_end = s_tuser | s_tlast;
    assign in_range = ({1'b0, ch} < (dle_pkg::CH_W+1)'(N_CHAN));

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // saturating accumulate
    assign sum_wide = {sum_reg[dle_pkg::SUM_W-1], sum_reg}
                    + {{(dle_pkg::SUM_W+1-dle_pkg::SAMPLE_W){sample[dle_pkg::SAMPLE_W-1]}},
                       sample};

    always_comb begin
        if (sum_wide > dle_pkg::SUM_MAX) begin
            sum_next = dle_pkg::SUM_MAX[dle_pkg::SUM_W-1:0];
        end else if (sum_wide < dle_pkg::SUM_MIN) begin
            sum_next = dle_pkg::SUM_MIN[dle_pkg::SUM_W-1:0];
        end else begin
            sum_next = sum_wide[dle_pkg::SUM_W-1:0];
        end
    end

    // frame count including the current frame
    assign cnt_inc = (frames_reg == dle_pkg::CNT_MAX) ? frames_reg
                                                      : frames_reg + 1'b1;

    // job issue on a channel end with a valid channel
    assign push           = accept && chan_end && in_range;
    assign job.sum        = sum_next;
    assign job.ch         = ch;
    assign job.reliable   = (cnt_inc >= reliable_count);
    assign job.frame_done = s_tlast;

    // accumulator and frame counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            frames_reg <= '0;
        end else if (accept) begin
            sum_reg <= chan_end ? '0 : sum_next;
            if (s_tlast) begin
                frames_reg <= cnt_inc;
            end
        end
    end

    `DLE_ASSERT_NEXT(a_frames_hold, accept && !s_tlast, $stable(frames_reg), "frame count moved")

endmodule

FILE: sv/dle_queue.sv
// short job queue decoupling the front end from the back end
// depends on dle_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dc_level_estimator_top_macros.svh"

module dle_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dle_pkg::dle_job_t job_in,
    input  logic              pop,
    output dle_pkg::dle_job_t job_out,
    output logic              full,
    output logic              empty
);

    dle_pkg::dle_job_t              entries_reg [dle_pkg::QUEUE_DEPTH];
    logic [dle_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [dle_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [dle_pkg::QUEUE_CW-1:0]   count_reg;

    assign full    = (count_reg == dle_pkg::QUEUE_CW'(dle_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = entries_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DLE_ASSERT_ALWAYS(a_count_bound, count_reg <= dle_pkg::QUEUE_CW'(dle_pkg::QUEUE_DEPTH), "queue count beyond depth")
    `DLE_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "job taken from empty queue")

endmodule

FILE: sv/dle_back.sv
// back end: mean, level update and result register
// depends on dle_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dc_level_estimator_top_macros.svh"

module dle_back #(
    parameter int N_CHAN = dle_pkg::N_CHAN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    input  dle_pkg::dle_job_t             job,
    output logic                          pop,
    input  logic [dle_pkg::RECIP_W-1:0]   recip,
    input  logic [dle_pkg::ALPHA_W-1:0]   alpha,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dle_pkg::M_TDATA_W-1:0] m_tdata,   // out_channel, dc_level, pad
    output logic                          m_tlast,   // frame_done
    output logic                          m_tuser    // reliable
);

    localparam int LVL_AW = (N_CHAN > 1) ? $clog2(N_CHAN) : 1;
    localparam int PROD_W = dle_pkg::SUM_W + dle_pkg::RECIP_W + 1;
    localparam int DIFF_W = dle_pkg::LEVEL_W + 1;
    localparam int STEP_W = DIFF_W + dle_pkg::ALPHA_W + 1;
    localparam int NEW_W  = STEP_W + 1;
    localparam int Q8_W   = dle_pkg::LEVEL_W + 1;

    localparam logic signed [PROD_W-1:0] MEAN_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] MEAN_MIN = PROD_W'(-64'sd2147483648);
    localparam logic signed [NEW_W-1:0]  LVL_MAX  = NEW_W'(64'sd2147483647);
    localparam logic signed [NEW_W-1:0]  LVL_MIN  = NEW_W'(-64'sd2147483648);
    localparam logic signed [Q8_W-1:0]   Q8_MAX   = Q8_W'(64'sd8388607);
    localparam logic signed [Q8_W-1:0]   Q8_MIN   = Q8_W'(-64'sd8388608);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MEAN  = 5'b00010,
        ST_DIFF  = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_WRITE = 5'b10000
    } back_state_t;

    back_state_t                             state_reg;
    dle_pkg::dle_job_t                       job_reg;
    logic signed [PROD_W-1:0]                prod_reg;
    logic signed [DIFF_W-1:0]                diff_reg;
    logic signed [STEP_W-1:0]                step_prod_reg;
    logic signed [dle_pkg::LEVEL_W-1:0]      levels_reg [N_CHAN];
    logic                                    m_valid_reg;
    logic [dle_pkg::CH_W-1:0]                out_ch_reg;
    logic signed [dle_pkg::OUT_LEVEL_W-1:0]  out_level_reg;
    logic                                    out_reliable_reg;
    logic                                    out_frame_reg;

    logic [LVL_AW-1:0]                       idx;
    logic signed [dle_pkg::LEVEL_W-1:0]      level_cur;
    logic signed [PROD_W-1:0]                prod_mul;
    logic signed [PROD_W-1:0]                mean_full;
    logic signed [dle_pkg::LEVEL_W-1:0]      mean_sat;
    logic signed [STEP_W-1:0]                step_mul;
    logic signed [STEP_W-1:0]                step_rnd;
    logic signed [NEW_W-1:0]                 level_wide;
    logic signed [dle_pkg::LEVEL_W-1:0]      level_new;
    logic signed [Q8_W-1:0]                  q8_full;
    logic signed [dle_pkg::OUT_LEVEL_W-1:0]  q8_sat;
    logic                                    out_free;
    logic                                    load_out;

    assign idx       = job_reg.ch[LVL_AW-1:0];
    assign level_cur = levels_reg[idx];
    assign pop       = (state_reg == ST_IDLE) && job_valid;
    assign out_free  = !m_valid_reg || m_tready;
    assign load_out  = (state_reg == ST_WRITE) && out_free;

    // sum times q24 reciprocal
    assign prod_mul = $signed(job_reg.sum) * $signed({1'b0, recip});

    // mean in q16 with round half up, saturated to 32 bits
    assign mean_full = (prod_reg + PROD_W'(128)) >>> 8;
    always_comb begin
        if (mean_full > MEAN_MAX) begin
            mean_sat = MEAN_MAX[dle_pkg::LEVEL_W-1:0];
        end else if (mean_full < MEAN_MIN) begin
            mean_sat = MEAN_MIN[dle_pkg::LEVEL_W-1:0];
        end else begin
            mean_sat = mean_full[dle_pkg::LEVEL_W-1:0];
        end
    end

    // alpha times distance to mean
    assign step_mul = $signed({1'b0, alpha}) * diff_reg;

    // rounded step added to the level with saturation
    assign step_rnd   = (step_prod_reg + STEP_W'(32768)) >>> 16;
    assign level_wide = NEW_W'(level_cur) + NEW_W'(step_rnd);
    always_comb begin
        if (level_wide > LVL_MAX) begin
            level_new = LVL_MAX[dle_pkg::LEVEL_W-1:0];
        end else if (level_wide < LVL_MIN) begin
            level_new = LVL_MIN[dle_pkg::LEVEL_W-1:0];
        end else begin
            level_new = level_wide[dle_pkg::LEVEL_W-1:0];
        end
    end

    // q15.8 output level
    assign q8_full = (Q8_W'(level_new) + Q8_W'(128)) >>> 8;
    always_comb begin
        if (q8_full > Q8_MAX) begin
            q8_sat = Q8_MAX[dle_pkg::OUT_LEVEL_W-1:0];
        end else if (q8_full < Q8_MIN) begin
            q8_sat = Q8_MIN[dle_pkg::OUT_LEVEL_W-1:0];
        end else begin
            q8_sat = q8_full[dle_pkg::OUT_LEVEL_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN:  state_reg <= ST_DIFF;
                ST_DIFF:  state_reg <= ST_STEP;
                ST_STEP:  state_reg <= ST_WRITE;
                ST_WRITE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath stage registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= job;
        end
        if (state_reg == ST_MEAN) begin
            prod_reg <= prod_mul;
        end
        if (state_reg == ST_DIFF) begin
            diff_reg <= DIFF_W'(mean_sat) - DIFF_W'(level_cur);
        end
        if (state_reg == ST_STEP) begin
            step_prod_reg <= step_mul;
        end
    end

    // per-channel levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_CHAN; i++) begin
                levels_reg[i] <= '0;
            end
        end else if (load_out) begin
            levels_reg[idx] <= level_new;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_ch_reg       <= job_reg.ch;
            out_level_reg    <= q8_sat;
            out_reliable_reg <= job_reg.reliable;
            out_frame_reg    <= job_reg.frame_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dle_pkg::M_TDATA_W-dle_pkg::OUT_LEVEL_W-dle_pkg::CH_W){1'b0}},
                       out_level_reg, out_ch_reg};
    assign m_tlast  = out_frame_reg;
    assign m_tuser  = out_reliable_reg;

    `DLE_ASSERT_NEXT(a_pop_starts_job, pop, state_reg == ST_MEAN, "sequencer missed a job")

endmodule

FILE: sv/dc_level_estimator_top.sv
// top level of the dc level estimator: config registers, front, queue, back
// depends on dle_pkg, dle_front, dle_queue and dle_back
`timescale 1ns / 1ps

// Per-channel DC level tracker for channel-major audio. Samples are taken one
// beat per cycle while the job queue has room; the front end sums each
// channel's frame in a saturating accumulator and, on the channel's last
// sample, hands the sum to a four-deep job queue. The back end turns each job
// into a mean (sum times the Q24 reciprocal), moves the channel's Q15.16 level
// toward it by alpha and returns the level in Q15.8 with a reliable flag. Each
// job steps through the back end in order: one state takes the job, three
// multiply and subtract stages follow, and one writes the level and result,
// waiting while the output is stalled. No new job is taken before that write,
// so short frames or a stalled output fill the queue and input is held off
// until the back end catches up. Input: tdata = sample then channel, tuser =
// end of channel, tlast = end of frame. Configuration must be written only
// while no job is in flight; the block itself does not enforce this.
module dc_level_estimator_top #(
    parameter int N_CHAN = dle_pkg::N_CHAN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dle_pkg::S_TDATA_W-1:0]  s_tdata,   // sample[15:0], channel[19:16], pad
    input  logic                           s_tlast,   // end_of_frame
    input  logic                           s_tuser,   // end_of_channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dle_pkg::M_TDATA_W-1:0]  m_tdata,   // out_channel[3:0], dc_level[27:4], pad
    output logic                           m_tlast,   // frame_done
    output logic                           m_tuser,   // reliable
    input  logic                           cfg_wr_en,
    input  logic [dle_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dle_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    logic [dle_pkg::RECIP_W-1:0] recip_reg;
    logic [dle_pkg::ALPHA_W-1:0] alpha_reg;
    logic [dle_pkg::CNT_W-1:0]   reliable_reg;

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    dle_pkg::dle_job_t job_in;
    dle_pkg::dle_job_t job_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg    <= dle_pkg::RECIP_RESET;
            alpha_reg    <= dle_pkg::ALPHA_RESET;
            reliable_reg <= dle_pkg::RELIABLE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dle_pkg::CFG_RECIP:    recip_reg    <= cfg_wr_data[dle_pkg::RECIP_W-1:0];
                dle_pkg::CFG_ALPHA:    alpha_reg    <= cfg_wr_data[dle_pkg::ALPHA_W-1:0];
                dle_pkg::CFG_RELIABLE: reliable_reg <= cfg_wr_data[dle_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sample accumulation and frame counting
    dle_front #(
        .N_CHAN(N_CHAN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tuser       (s_tuser),
        .reliable_count(reliable_reg),
        .queue_full    (queue_full),
        .push          (push),
        .job           (job_in)
    );

    // job queue
    dle_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .job_in (job_in),
        .pop    (pop),
        .job_out(job_out),
        .full   (queue_full),
        .empty  (queue_empty)
    );

    // level update and results
    dle_back #(
        .N_CHAN(N_CHAN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(!queue_empty),
        .job      (job_out),
        .pop      (pop),
        .recip    (recip_reg),
        .alpha    (alpha_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
